### hw/rtl/mpct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared constants, register map and configuration type for the mouse
// packet cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

	// Coordinate width default and configuration register width
	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_BITS       = 12;

	// APB port geometry
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	// Register reset values
	localparam logic [CFG_BITS-1:0] WIDTH_RST  = 12'd1024;
	localparam logic [CFG_BITS-1:0] HEIGHT_RST = 12'd768;

	// Register indexes (word address bit above the byte offset)
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// Position of the next byte within a packet
	localparam logic [1:0] IDX_HEADER = 2'd0;
	localparam logic [1:0] IDX_SECOND = 2'd1;
	localparam logic [1:0] IDX_THIRD  = 2'd2;

	// Header byte bit positions
	localparam int HDR_SYNC_BIT = 3;
	localparam int HDR_XSGN_BIT = 4;
	localparam int HDR_YSGN_BIT = 5;
	localparam int HDR_XOVF_BIT = 6;
	localparam int HDR_YOVF_BIT = 7;

	typedef struct packed {
		logic [CFG_BITS-1:0] screen_width;
		logic [CFG_BITS-1:0] screen_height;
	} cfg_t;

endpackage
`default_nettype wire

### hw/rtl/mpct_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpct_apb_regs
// APB register file holding the screen clamp limits.
// ----------------------------------------------------------------------------
module mpct_apb_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [mpct_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [mpct_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [mpct_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                    pready,
	output mpct_pkg::cfg_t                          cfg
);
	import mpct_pkg::*;

	logic   wr_en;
	logic   reg_sel;
	cfg_t   cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[APB_ADDR_BITS-1];

	// Write the addressed limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= WIDTH_RST;
			cfg_q.screen_height <= HEIGHT_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[CFG_BITS-1:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back, zero-extended
	always_comb begin
		case (reg_sel)
			REG_SCREEN_WIDTH:  prdata = APB_DATA_BITS'(cfg_q.screen_width);
			REG_SCREEN_HEIGHT: prdata = APB_DATA_BITS'(cfg_q.screen_height);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### hw/rtl/mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker
// Assembles 3-byte mouse packets, decodes buttons and deltas, and tracks a
// clamped cursor position.
// ----------------------------------------------------------------------------
// Bytes enter through an input register and are taken at up to one per clock
// while in_stall is low. A header byte whose bit 3 is clear is dropped while
// the block waits for a packet start. On the third byte of a packet the
// decode and the cursor update (add X, subtract Y, clamp each axis to
// 0..limit) are combinational into the result register, after the input
// register that held it. One byte may wait in the input register while a
// result is held by the downstream side; only a byte that completes a packet
// waits for the result register. Clamp limits are set over the APB port at
// byte addresses 0 (width) and 4 (height) and should be changed only when
// the block is idle.
module mouse_packet_cursor_tracker #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [mpct_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [mpct_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic      [mpct_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                                    pready,
	// byte input
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [7:0]                         data_byte,
	// packet results
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    left_button,
	output logic                                    right_button,
	output logic                                    middle_button,
	output logic signed [8:0]                       delta_x,
	output logic signed [8:0]                       delta_y,
	output logic                                    x_overflow,
	output logic                                    y_overflow,
	output logic      [COORD_BITS-1:0]              pointer_x,
	output logic      [COORD_BITS-1:0]              pointer_y,
	output logic                                    any_pressed,
	output logic                                    any_released
);
	import mpct_pkg::*;

	localparam int LW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
	localparam logic signed [LW-1:0] CMAX = LW'((1 << COORD_BITS) - 1);

	cfg_t cfg;

	mpct_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp one axis to 0..min(limit, coordinate maximum)
	function automatic logic [COORD_BITS-1:0] clamp_axis(
		input logic signed [LW-1:0] v,
		input logic [CFG_BITS-1:0]  lim
	);
		logic signed [LW-1:0] lim_ext;
		logic signed [LW-1:0] hi;
		logic signed [LW-1:0] r;
		lim_ext = $signed({{(LW-CFG_BITS){1'b0}}, lim});
		hi      = (lim_ext > CMAX) ? CMAX : lim_ext;
		if (v < 0)       r = '0;
		else if (v > hi) r = hi;
		else             r = v;
		return r[COORD_BITS-1:0];
	endfunction

	// Input register and packet state
	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic [1:0]            byte_idx_q;
	logic [7:0]            first_byte_q;
	logic [7:0]            second_byte_q;
	logic [COORD_BITS-1:0] cursor_x_q;
	logic [COORD_BITS-1:0] cursor_y_q;
	logic [2:0]            prev_buttons_q;

	logic                  completes;
	logic                  out_free;
	logic                  adv_s1;
	logic                  out_load;
	logic                  in_take;

	logic [2:0]            buttons;
	logic signed [8:0]     dx;
	logic signed [8:0]     dy;
	logic signed [LW-1:0]  sum_x;
	logic signed [LW-1:0]  sum_y;
	logic [COORD_BITS-1:0] next_x;
	logic [COORD_BITS-1:0] next_y;

	// Flow control: the held byte moves on unless it completes a packet
	// and the result register is still occupied
	assign completes = (byte_idx_q == IDX_THIRD);
	assign out_free  = ~out_valid | ~out_stall;
	assign adv_s1    = valid_s1 & (~completes | out_free);
	assign out_load  = adv_s1 & completes;
	assign in_stall  = valid_s1 & ~adv_s1;
	assign in_take   = in_valid & ~in_stall;

	// Decode the packet from the two held bytes and the incoming third one
	always_comb begin
		buttons = first_byte_q[2:0];
		dx      = $signed({first_byte_q[HDR_XSGN_BIT], second_byte_q});
		dy      = $signed({first_byte_q[HDR_YSGN_BIT], byte_s1});
		sum_x   = $signed({{(LW-COORD_BITS){1'b0}}, cursor_x_q}) + LW'(dx);
		sum_y   = $signed({{(LW-COORD_BITS){1'b0}}, cursor_y_q}) - LW'(dy);
		next_x  = clamp_axis(sum_x, cfg.screen_width);
		next_y  = clamp_axis(sum_y, cfg.screen_height);
	end

	// Hold the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
		end
	end

	// Advance packet assembly and the cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q     <= IDX_HEADER;
			first_byte_q   <= '0;
			second_byte_q  <= '0;
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			prev_buttons_q <= '0;
		end else if (adv_s1) begin
			case (byte_idx_q)
				IDX_HEADER: begin
					if (byte_s1[HDR_SYNC_BIT]) begin
						first_byte_q <= byte_s1;
						byte_idx_q   <= IDX_SECOND;
					end
				end
				IDX_SECOND: begin
					second_byte_q <= byte_s1;
					byte_idx_q    <= IDX_THIRD;
				end
				IDX_THIRD: begin
					cursor_x_q     <= next_x;
					cursor_y_q     <= next_y;
					prev_buttons_q <= buttons;
					byte_idx_q     <= IDX_HEADER;
				end
				default: byte_idx_q <= IDX_HEADER;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_free) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_button   <= buttons[0];
			right_button  <= buttons[1];
			middle_button <= buttons[2];
			delta_x       <= dx;
			delta_y       <= dy;
			x_overflow    <= first_byte_q[HDR_XOVF_BIT];
			y_overflow    <= first_byte_q[HDR_YOVF_BIT];
			pointer_x     <= next_x;
			pointer_y     <= next_y;
			any_pressed   <= |buttons;
			any_released  <= |(prev_buttons_q & ~buttons);
		end
	end

	// Checks
	a_idx_legal: assert property (@(posedge clk) disable iff (!arst_n)
		byte_idx_q == IDX_HEADER || byte_idx_q == IDX_SECOND || byte_idx_q == IDX_THIRD)
		else $error("packet byte index out of range");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> byte_idx_q == IDX_HEADER)
		else $error("packet index did not return to header after a result");

	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && completes && out_valid && out_stall))
		else $error("input stalled without a blocked packet");

	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pointer_x <= cfg.screen_width))
		else $error("cursor X beyond screen width");

	a_clamp_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pointer_y <= cfg.screen_height))
		else $error("cursor Y beyond screen height");

endmodule
`default_nettype wire

### tb/sv/mpct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_checker
// Watches the byte, result and APB channels of the mouse packet cursor
// tracker. It keeps its own copy of the packet assembly, the clamp limits
// and the cursor, predicts each packet result and compares every result
// beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mpct_checker #(
	parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [mpct_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire logic [mpct_pkg::APB_DATA_BITS-1:0] pwdata,
	input  wire logic                               pready,
	input  wire logic                               in_valid,
	input  wire logic                               in_stall,
	input  wire logic [7:0]                         data_byte,
	input  wire logic                               out_valid,
	input  wire logic                               out_stall,
	input  wire logic                               left_button,
	input  wire logic                               right_button,
	input  wire logic                               middle_button,
	input  wire logic signed [8:0]                  delta_x,
	input  wire logic signed [8:0]                  delta_y,
	input  wire logic                               x_overflow,
	input  wire logic                               y_overflow,
	input  wire logic [COORD_BITS-1:0]              pointer_x,
	input  wire logic [COORD_BITS-1:0]              pointer_y,
	input  wire logic                               any_pressed,
	input  wire logic                               any_released,
	output int                                      fail_count,
	output int                                      outstanding
);
	import mpct_pkg::*;

	localparam int SHOW_LIMIT = 10;
	localparam int COORD_TOP  = (1 << COORD_BITS) - 1;

	localparam logic [APB_ADDR_BITS-1:0] ADDR_WIDTH  = {REG_SCREEN_WIDTH, 2'b00};
	localparam logic [APB_ADDR_BITS-1:0] ADDR_HEIGHT = {REG_SCREEN_HEIGHT, 2'b00};

	typedef enum logic [1:0] {AT_HEADER, AT_SECOND, AT_THIRD} byte_pos_t;

	typedef struct packed {
		logic                  btn_l;
		logic                  btn_r;
		logic                  btn_m;
		logic [8:0]            dx;
		logic [8:0]            dy;
		logic                  xovf;
		logic                  yovf;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic                  pressed;
		logic                  released;
	} packet_t;

	// Mirror of the tracker state
	byte_pos_t             byte_pos;
	logic [7:0]            hdr_byte;
	logic [7:0]            x_byte;
	logic [COORD_BITS-1:0] cur_x;
	logic [COORD_BITS-1:0] cur_y;
	logic [2:0]            last_btns;
	logic [CFG_BITS-1:0]   lim_w;
	logic [CFG_BITS-1:0]   lim_h;
	packet_t               due_packets[$];
	int                    shown;

	// Clamp to 0..limit, the limit itself capped at the coordinate range
	function automatic logic [COORD_BITS-1:0] clamp_axis(input int v, input logic [CFG_BITS-1:0] lim);
		int hi;
		hi = int'(lim);
		if (hi > COORD_TOP)
			hi = COORD_TOP;
		if (v < 0)
			return '0;
		if (v > hi)
			return hi[COORD_BITS-1:0];
		return v[COORD_BITS-1:0];
	endfunction

	// Decode a finished packet, move the cursor and remember the buttons
	function automatic packet_t decode_packet(input logic [7:0] y_byte);
		packet_t p;
		int dx;
		int dy;
		dx = hdr_byte[HDR_XSGN_BIT] ? int'(x_byte) - 256 : int'(x_byte);
		dy = hdr_byte[HDR_YSGN_BIT] ? int'(y_byte) - 256 : int'(y_byte);
		cur_x = clamp_axis(int'(cur_x) + dx, lim_w);
		cur_y = clamp_axis(int'(cur_y) - dy, lim_h);
		p.btn_l    = hdr_byte[0];
		p.btn_r    = hdr_byte[1];
		p.btn_m    = hdr_byte[2];
		p.dx       = dx[8:0];
		p.dy       = dy[8:0];
		p.xovf     = hdr_byte[HDR_XOVF_BIT];
		p.yovf     = hdr_byte[HDR_YOVF_BIT];
		p.px       = cur_x;
		p.py       = cur_y;
		p.pressed  = |hdr_byte[2:0];
		p.released = |(last_btns & ~hdr_byte[2:0]);
		last_btns  = hdr_byte[2:0];
		return p;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fail_count++;
			shown++;
			if (shown <= SHOW_LIMIT)
				$display("mpct_checker: %s expected 'h%0h got 'h%0h at %0t",
					name, want, got, $time);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		packet_t want;
		if (!arst_n) begin
			byte_pos    = AT_HEADER;
			hdr_byte    = '0;
			x_byte      = '0;
			cur_x       = '0;
			cur_y       = '0;
			last_btns   = '0;
			lim_w       = 12'd1024;
			lim_h       = 12'd768;
			shown       = 0;
			fail_count  = 0;
			due_packets.delete();
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_WIDTH)
					lim_w = pwdata[CFG_BITS-1:0];
				else if (paddr == ADDR_HEIGHT)
					lim_h = pwdata[CFG_BITS-1:0];
			end

			// Advance packet assembly on each byte beat
			if (in_valid && !in_stall) begin
				case (byte_pos)
					AT_HEADER: begin
						if (data_byte[HDR_SYNC_BIT]) begin
							hdr_byte = data_byte;
							byte_pos = AT_SECOND;
						end
					end
					AT_SECOND: begin
						x_byte   = data_byte;
						byte_pos = AT_THIRD;
					end
					default: begin
						due_packets.push_back(decode_packet(data_byte));
						byte_pos = AT_HEADER;
					end
				endcase
			end

			// Compare each result beat with the oldest prediction
			if (out_valid && !out_stall) begin
				if (due_packets.size() == 0) begin
					fail_count++;
					shown++;
					if (shown <= SHOW_LIMIT)
						$display("mpct_checker: result beat with no packet pending at %0t",
							$time);
				end else begin
					want = due_packets.pop_front();
					check_field("left_button", want.btn_l, left_button);
					check_field("right_button", want.btn_r, right_button);
					check_field("middle_button", want.btn_m, middle_button);
					check_field("delta_x", want.dx, $unsigned(delta_x));
					check_field("delta_y", want.dy, $unsigned(delta_y));
					check_field("x_overflow", want.xovf, x_overflow);
					check_field("y_overflow", want.yovf, y_overflow);
					check_field("pointer_x", want.px, pointer_x);
					check_field("pointer_y", want.py, pointer_y);
					check_field("any_pressed", want.pressed, any_pressed);
					check_field("any_released", want.released, any_released);
				end
			end
		end
		outstanding = due_packets.size();
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives mouse bytes and clamp limit writes into the cursor tracker, with
// random sender gaps and receiver stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import mpct_pkg::*;

	localparam int IDLE_LIMIT     = 2000;
	localparam int PKTS_PER_PHASE = 30;
	localparam int NUM_PHASES     = 8;
	localparam int SETTLE_CYCLES  = 8;

	localparam logic [APB_ADDR_BITS-1:0] ADDR_WIDTH  = {REG_SCREEN_WIDTH, 2'b00};
	localparam logic [APB_ADDR_BITS-1:0] ADDR_HEIGHT = {REG_SCREEN_HEIGHT, 2'b00};

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_stall;
	logic [7:0]               data_byte;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     left_button;
	logic                     right_button;
	logic                     middle_button;
	logic signed [8:0]        delta_x;
	logic signed [8:0]        delta_y;
	logic                     x_overflow;
	logic                     y_overflow;
	logic [COORD_BITS_DEF-1:0] pointer_x;
	logic [COORD_BITS_DEF-1:0] pointer_y;
	logic                     any_pressed;
	logic                     any_released;

	int fail_count;
	int outstanding;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	// Idling per phase: none, sender only, receiver only, both lightly
	int send_pct_tab[4]  = '{0, 52, 0, 8};
	int recv_pct_tab[4]  = '{0, 0, 52, 8};
	// Clamp limits per phase, -1 picks a random value
	int width_tab[NUM_PHASES]  = '{0, 4095, 37, -1, 4095, 1, 2000, -1};
	int height_tab[NUM_PHASES] = '{0, 4095, 4095, -1, 0, 60, 1, -1};

	mouse_packet_cursor_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_button(left_button), .right_button(right_button),
		.middle_button(middle_button), .delta_x(delta_x), .delta_y(delta_y),
		.x_overflow(x_overflow), .y_overflow(y_overflow),
		.pointer_x(pointer_x), .pointer_y(pointer_y),
		.any_pressed(any_pressed), .any_released(any_released)
	);

	mpct_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_button(left_button), .right_button(right_button),
		.middle_button(middle_button), .delta_x(delta_x), .delta_y(delta_y),
		.x_overflow(x_overflow), .y_overflow(y_overflow),
		.pointer_x(pointer_x), .pointer_y(pointer_y),
		.any_pressed(any_pressed), .any_released(any_released),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result channel at random
	always @(negedge clk)
		out_stall = ($urandom_range(99) < recv_stall_pct);

	// Abort when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready))
			quiet_cycles <= 0;
		else if (quiet_cycles == IDLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Offer one byte, with random gaps ahead of it, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid  = 1'b0;
			data_byte = 8'($urandom);
			@(negedge clk);
		end
		in_valid  = 1'b1;
		data_byte = b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
		send_byte(hdr);
		send_byte(xb);
		send_byte(yb);
	endtask

	// Drop valid, wait for every pending result, then let a held byte drain
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle until pready
	task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr, input logic [CFG_BITS-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = {20'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Mostly well-formed packets drifting one way, with stray and broken ones
	task automatic run_phase(input logic x_neg, input logic y_neg);
		logic [7:0] hdr;
		int kind;
		for (int i = 0; i < PKTS_PER_PHASE; i++) begin
			kind = $urandom_range(99);
			hdr  = 8'($urandom);
			hdr[HDR_SYNC_BIT] = 1'b1;
			if ($urandom_range(9) < 8)
				hdr[HDR_XSGN_BIT] = x_neg;
			if ($urandom_range(9) < 8)
				hdr[HDR_YSGN_BIT] = y_neg;
			if (kind < 8)
				send_byte(8'($urandom));
			else if (kind < 12) begin
				send_byte(hdr);
				send_byte(8'($urandom));
			end else
				send_packet(hdr, 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int w;
		int h;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		data_byte = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: dropped headers, zero move, extreme deltas, overflow flags
		send_byte(8'h00);
		send_byte(8'hF7);
		send_packet(8'h08, 8'h00, 8'h00);
		send_packet(8'h0F, 8'hFF, 8'h00);
		send_packet(8'h18, 8'h00, 8'h00);
		send_packet(8'h28, 8'h00, 8'h00);
		send_packet(8'hC8, 8'h7F, 8'h80);
		send_packet(8'hFF, 8'hFF, 8'hFF);

		// Random phases, each with its own limits and idling
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			w = (width_tab[ph] < 0) ? $urandom_range(4095) : width_tab[ph];
			h = (height_tab[ph] < 0) ? $urandom_range(4095) : height_tab[ph];
			write_reg(ADDR_WIDTH, w[CFG_BITS-1:0]);
			write_reg(ADDR_HEIGHT, h[CFG_BITS-1:0]);
			send_idle_pct  = send_pct_tab[ph % 4];
			recv_stall_pct = recv_pct_tab[ph % 4];
			run_phase(ph[1], ~ph[1]);
		end

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
